// File: rtl/polysub_pkg.sv
// shared constants for the polyalphabetic substitution block
package polysub_pkg;

   // letters per key alphabet
   localparam int ALPHA = 26;

   // default number of key alphabets held
   localparam int MAX_KEYS_DEF = 8;

   // widest value that the key count register can hold
   localparam int NUM_KEYS_REG_MAX = 15;

   // request kinds
   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_LETTER  = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_KEYS    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECODE_MODE = 1'd1;

endpackage

// File: rtl/polyalphabetic_substitution.sv
// polyalphabetic substitution cipher with key alphabets in rotation
//
// The block holds up to MAX_KEYS key alphabets of 26 letters in a key memory
// with a write port and a registered read port (one write, one registered
// read per cycle) and applies them in rotation by message position. A load
// request writes one key entry (out of range loads are dropped) and a restart
// request sets the position to zero; neither gives a response. A letter
// request picks the alphabet of the current position and then advances the
// position modulo num_keys (0 acts as 1, values above MAX_KEYS act as
// MAX_KEYS). In encode mode a letter gives one response, the key entry at
// that letter, read into the read register and then placed in the output
// register once that is free; the next request can be taken once the
// response is placed there; a letter above 25 gives no response. In decode
// mode the alphabet is scanned through the memory read port one entry per
// cycle, while no match waits on a full response register, in ascending
// order, and every matching index is sent, the final one with rsp_last set.
// A decode holds the block through the 26 reads, the compare of the last
// entry read and the sending of the final match, and longer while a match
// waits on a full response register. req_ready is high only while no letter
// is in progress. A response waits in an output register, so a new request
// can be taken while the previous response has not been taken yet.
// The key memory is not cleared after reset: an entry must be loaded before
// any letter reads it.
module polyalphabetic_substitution #(
   parameter int MAX_KEYS = polysub_pkg::MAX_KEYS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write port
   input  logic                                csr_we,
   input  logic [polysub_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [polysub_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_kind,
   input  logic [2:0]                          req_key_select,
   input  logic [4:0]                          req_entry_index,
   input  logic [4:0]                          req_letter,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [4:0]                          rsp_out_letter,
   output logic                                rsp_last
);

   // largest effective key count: bounded by storage and by the register width
   localparam int NK_MAX = (MAX_KEYS < polysub_pkg::NUM_KEYS_REG_MAX) ?
                           MAX_KEYS : polysub_pkg::NUM_KEYS_REG_MAX;
   localparam int POS_W = (NK_MAX > 1) ? $clog2(NK_MAX) : 1;
   localparam int ROW_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   // each alphabet occupies a row of 32 words, entry index in the low bits
   localparam int ADDR_W = ROW_W + 5;
   localparam int DEPTH = 1 << ADDR_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENC_OUT,
      ST_SEARCH
   } state_type;

   // key memory
   logic [4:0]        key_mem [0:DEPTH-1];
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [4:0]        rd_ff;

   // control state
   state_type         state_ff, state_in;
   logic [3:0]        num_keys_ff, num_keys_in;
   logic              decode_mode_ff, decode_mode_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [4:0]        j_ff, j_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [4:0]        letter_ff, letter_in;
   logic [4:0]        cmp_idx_ff, cmp_idx_in;
   logic [4:0]        pend_idx_ff, pend_idx_in;
   logic [4:0]        rsp_letter_ff, rsp_letter_in;
   logic              rsp_last_ff, rsp_last_in;

   // position and rotation
   logic [3:0]        nk_eff;
   logic [POS_W-1:0]  pos_cur;
   logic [4:0]        pos_inc;
   logic [POS_W-1:0]  pos_next;

   logic              out_free;
   logic              match;
   logic              scan_done;

   // clamp the key count into 1..NK_MAX
   always_comb begin
      if (num_keys_ff == 4'd0) begin
         nk_eff = 4'd1;
      end else if (num_keys_ff > 4'(NK_MAX)) begin
         nk_eff = 4'(NK_MAX);
      end else begin
         nk_eff = num_keys_ff;
      end
   end

   // a position left beyond a lowered count restarts at zero
   assign pos_cur  = (4'(pos_ff) < nk_eff) ? pos_ff : '0;
   assign pos_inc  = 5'(pos_cur) + 5'd1;
   assign pos_next = (pos_inc >= 5'(nk_eff)) ? '0 : POS_W'(pos_inc);

   // output register can take a new response this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // read data in rd_ff belongs to entry cmp_idx_ff of the current alphabet
   assign match     = cmp_valid_ff && (rd_ff == letter_ff);
   assign scan_done = !cmp_valid_ff && (j_ff == 5'(polysub_pkg::ALPHA));

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_letter = rsp_letter_ff;
   assign rsp_last       = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      num_keys_in    = num_keys_ff;
      decode_mode_in = decode_mode_ff;
      pos_in         = pos_ff;
      j_in           = j_ff;
      cmp_valid_in   = cmp_valid_ff;
      pend_valid_in  = pend_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      row_in         = row_ff;
      letter_in      = letter_ff;
      cmp_idx_in     = cmp_idx_ff;
      pend_idx_in    = pend_idx_ff;
      rsp_letter_in  = rsp_letter_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = {ROW_W'(req_key_select), req_entry_index};
      rd_en          = 1'b0;
      rd_addr        = {row_ff, j_ff};

      // response taken
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            polysub_pkg::CSR_NUM_KEYS:    num_keys_in = csr_wdata;
            polysub_pkg::CSR_DECODE_MODE: decode_mode_in = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  polysub_pkg::KIND_LOAD: begin
                     // out of range loads are dropped
                     wr_en = (32'(req_key_select) < MAX_KEYS) &&
                             (req_entry_index < 5'(polysub_pkg::ALPHA));
                  end
                  polysub_pkg::KIND_RESTART: begin
                     pos_in = '0;
                  end
                  polysub_pkg::KIND_LETTER: begin
                     pos_in    = pos_next;
                     row_in    = ROW_W'(pos_cur);
                     letter_in = req_letter;
                     if (decode_mode_ff) begin
                        state_in      = ST_SEARCH;
                        j_in          = 5'd0;
                        cmp_valid_in  = 1'b0;
                        pend_valid_in = 1'b0;
                     end else if (req_letter < 5'(polysub_pkg::ALPHA)) begin
                        rd_en    = 1'b1;
                        rd_addr  = {ROW_W'(pos_cur), req_letter};
                        state_in = ST_ENC_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_ENC_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_letter_in = rd_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_SEARCH: begin
            if (scan_done) begin
               // the held match is the final one
               if (!pend_valid_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_letter_in = pend_idx_ff;
                  rsp_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else if (!(match && pend_valid_ff) || out_free) begin
               // a new match proves the held one was not the last
               if (match && pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_letter_in = pend_idx_ff;
                  rsp_last_in   = 1'b0;
               end
               if (match) begin
                  pend_valid_in = 1'b1;
                  pend_idx_in   = cmp_idx_ff;
               end
               if (j_ff < 5'(polysub_pkg::ALPHA)) begin
                  rd_en        = 1'b1;
                  rd_addr      = {row_ff, j_ff};
                  cmp_idx_in   = j_ff;
                  cmp_valid_in = 1'b1;
                  j_in         = j_ff + 5'd1;
               end else begin
                  cmp_valid_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         num_keys_ff    <= 4'd1;
         decode_mode_ff <= 1'b0;
         pos_ff         <= '0;
         j_ff           <= 5'd0;
         cmp_valid_ff   <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         num_keys_ff    <= num_keys_in;
         decode_mode_ff <= decode_mode_in;
         pos_ff         <= pos_in;
         j_ff           <= j_in;
         cmp_valid_ff   <= cmp_valid_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      row_ff        <= row_in;
      letter_ff     <= letter_in;
      cmp_idx_ff    <= cmp_idx_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_letter_ff <= rsp_letter_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // key memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= req_letter;
      end
   end

   // key memory read port, data held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= key_mem[rd_addr];
      end
   end

`ifndef SYNTHESIS
   // the message position never leaves the rotation range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < NK_MAX)
      else $error("message position out of range");

   // a held decode match exists only during a scan
   a_pend_in_search: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_SEARCH))
      else $error("pending match outside of a scan");

   // the scan index never runs past the alphabet
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (j_ff <= 5'(polysub_pkg::ALPHA)))
      else $error("scan index past the alphabet");
`endif

endmodule

// File: bench/testbench.sv
// self-checking testbench for the polyalphabetic substitution block
module testbench;

   localparam int KEYS = polysub_pkg::MAX_KEYS_DEF;
   localparam int ALPHA = polysub_pkg::ALPHA;
   // the fourth request kind, which the block ignores
   localparam logic [1:0] KIND_IGNORED = 2'd3;
   // a decode scans 26 entries plus the read pipeline, so idle this long
   localparam int SETTLE_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 11;
   localparam int PHASES = 8;
   // value that fills the whole last alphabet, so one decode hits all entries
   localparam logic [4:0] FLOOD_LETTER = 5'd13;

   typedef struct packed {
      logic [4:0] letter;
      logic       last;
   } rsp_type;

   // one opening request; typed rows carry their expected response
   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] ksel;
      logic [4:0] eidx;
      logic [4:0] letter;
      logic       typed;
      logic       has_out;
      logic [4:0] out_letter;
   } row_type;

   logic                               clock;
   logic                               reset;
   logic                               csr_we;
   logic [polysub_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [polysub_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic                               req_valid;
   logic                               req_ready;
   logic [1:0]                         req_kind;
   logic [2:0]                         req_key_select;
   logic [4:0]                         req_entry_index;
   logic [4:0]                         req_letter;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [4:0]                         rsp_out_letter;
   logic                               rsp_last;

   // responses still owed by the block, oldest first
   rsp_type    due_letters [$];
   // local copy of the key alphabets, position and registers
   logic [4:0] alphabets [KEYS][ALPHA];
   int         text_pos;
   logic [3:0] num_keys_r;
   logic       decode_r;
   int         errors;
   bit         sender_gaps;

   // opening requests: encode mode, one alphabet, so position stays 0
   row_type opening [17] = '{
      {polysub_pkg::KIND_LOAD,    3'd0, 5'd0,  5'd25, 1'b1, 1'b0, 5'd0},
      {polysub_pkg::KIND_LOAD,    3'd0, 5'd25, 5'd0,  1'b1, 1'b0, 5'd0},
      // value above 25 is kept as its five bits
      {polysub_pkg::KIND_LOAD,    3'd0, 5'd7,  5'd31, 1'b1, 1'b0, 5'd0},
      {polysub_pkg::KIND_LOAD,    3'd7, 5'd25, 5'd31, 1'b1, 1'b0, 5'd0},
      // entry index out of range, must not land anywhere
      {polysub_pkg::KIND_LOAD,    3'd0, 5'd31, 5'd0,  1'b1, 1'b0, 5'd0},
      {polysub_pkg::KIND_LETTER,  3'd0, 5'd0,  5'd0,  1'b1, 1'b1, 5'd25},
      {polysub_pkg::KIND_LETTER,  3'd7, 5'd31, 5'd25, 1'b1, 1'b1, 5'd0},
      {polysub_pkg::KIND_LETTER,  3'd0, 5'd0,  5'd7,  1'b1, 1'b1, 5'd31},
      // encode of a non-letter gives nothing
      {polysub_pkg::KIND_LETTER,  3'd0, 5'd0,  5'd26, 1'b1, 1'b0, 5'd0},
      {polysub_pkg::KIND_LETTER,  3'd0, 5'd0,  5'd31, 1'b1, 1'b0, 5'd0},
      {polysub_pkg::KIND_RESTART, 3'd0, 5'd0,  5'd0,  1'b1, 1'b0, 5'd0},
      {KIND_IGNORED,              3'd7, 5'd31, 5'd31, 1'b1, 1'b0, 5'd0},
      // overwrite an entry, then read it back through the predictor
      {polysub_pkg::KIND_LOAD,    3'd0, 5'd0,  5'd1,  1'b1, 1'b0, 5'd0},
      {polysub_pkg::KIND_LETTER,  3'd0, 5'd0,  5'd0,  1'b0, 1'b0, 5'd0},
      {polysub_pkg::KIND_LOAD,    3'd0, 5'd12, 5'd12, 1'b1, 1'b0, 5'd0},
      {polysub_pkg::KIND_LETTER,  3'd5, 5'd9,  5'd12, 1'b0, 1'b0, 5'd0},
      {polysub_pkg::KIND_RESTART, 3'd7, 5'd31, 5'd31, 1'b1, 1'b0, 5'd0}
   };

   // register settings per phase: zero and fifteen hit the clamps
   logic [3:0] phase_keys [PHASES] = '{4'd8, 4'd3, 4'd0, 4'd15, 4'd8, 4'd6, 4'd1, 4'd2};
   logic       phase_dec  [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

   polyalphabetic_substitution u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_key_select  (req_key_select),
      .req_entry_index (req_entry_index),
      .req_letter      (req_letter),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_letter  (rsp_out_letter),
      .rsp_last        (rsp_last)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // key count as the block applies it
   function automatic int keys_in_use();
      if (num_keys_r == 4'd0) return 1;
      if (int'(num_keys_r) > KEYS) return KEYS;
      return int'(num_keys_r);
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // letter for a process request; in decode, favor values that will match
   function automatic logic [4:0] pick_letter();
      int r;
      int p;
      r = $urandom_range(0, 99);
      p = (text_pos < keys_in_use()) ? text_pos : 0;
      if (decode_r && r < 60) return alphabets[p][$urandom_range(0, ALPHA - 1)];
      if (r < 88) return 5'($urandom_range(0, ALPHA - 1));
      return 5'($urandom_range(ALPHA, 31));
   endfunction

   // applies one accepted request to the local state, queues the responses
   task automatic substitute(input logic [1:0] kind, input logic [2:0] ksel,
                             input logic [4:0] eidx, input logic [4:0] ltr, input bit keep);
      int      eff;
      int      p;
      rsp_type hits [$];
      eff = keys_in_use();
      case (kind)
         polysub_pkg::KIND_LOAD: begin
            if (int'(ksel) < KEYS && eidx < ALPHA) alphabets[ksel][eidx] = ltr;
         end
         polysub_pkg::KIND_RESTART: begin
            text_pos = 0;
         end
         polysub_pkg::KIND_LETTER: begin
            // a position left over from a larger key count acts as 0
            p = (text_pos < eff) ? text_pos : 0;
            if (!decode_r) begin
               if (ltr < ALPHA) hits.push_back({alphabets[p][ltr], 1'b1});
            end else begin
               // every matching index in ascending order, last one flagged
               for (int j = 0; j < ALPHA; j++)
                  if (alphabets[p][j] == ltr) hits.push_back({5'(j), 1'b0});
               if (hits.size() > 0) hits[hits.size() - 1].last = 1'b1;
            end
            text_pos = (p + 1 >= eff) ? 0 : p + 1;
         end
         default: begin
         end
      endcase
      if (keep) foreach (hits[i]) due_letters.push_back(hits[i]);
   endtask

   // drives one request at the falling edge and holds it until taken
   task automatic send_request(input logic [1:0] kind, input logic [2:0] ksel,
                               input logic [4:0] eidx, input logic [4:0] ltr,
                               input bit typed, input bit has_out, input logic [4:0] out_letter);
      int gap;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_key_select  <= ksel;
      req_entry_index <= eidx;
      req_letter      <= ltr;
      do @(posedge clock); while (!req_ready);
      // typed rows still update the local state, but their response is given
      substitute(kind, ksel, eidx, ltr, !typed);
      if (typed && has_out) due_letters.push_back({out_letter, 1'b1});
      gap = sender_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop sending and let every owed response and any silent decode finish
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_letters.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [polysub_pkg::CSR_IDX_W-1:0] idx,
                            input logic [polysub_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == polysub_pkg::CSR_NUM_KEYS) num_keys_r = data;
      else decode_r = data[0];
   endtask

   // response side: ready bursts, short stalls, occasional long stalls
   initial begin
      int span;
      forever begin
         rsp_ready <= 1'b1;
         span = $urandom_range(1, 4) + (($urandom_range(0, 3) == 0) ? 40 : 0);
         repeat (span) @(negedge clock);
         span = pick_gap();
         if (span > 0) begin
            rsp_ready <= 1'b0;
            repeat (span) @(negedge clock);
         end
      end
   end

   // compare each taken response with the oldest owed one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_letters.size() == 0) begin
            $display("%0t: expected no response, got letter %0d last %0b", $time,
                     rsp_out_letter, rsp_last);
            errors++;
         end else begin
            want = due_letters.pop_front();
            if (rsp_out_letter !== want.letter) begin
               $display("%0t: out_letter expected %0d got %0d", $time, want.letter,
                        rsp_out_letter);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0b got %0b", $time, want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // hard limit on the whole run
   initial begin
      #40000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int counted;
      int r;
      logic [4:0] eidx;
      logic [4:0] val;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_kind        = polysub_pkg::KIND_LOAD;
      req_key_select  = '0;
      req_entry_index = '0;
      req_letter      = '0;
      errors          = 0;
      text_pos        = 0;
      num_keys_r      = 4'd1;
      decode_r        = 1'b0;
      sender_gaps     = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed requests with the reset settings
      foreach (opening[i])
         send_request(opening[i].kind, opening[i].ksel, opening[i].eidx, opening[i].letter,
                      opening[i].typed, opening[i].has_out, opening[i].out_letter);

      // load every alphabet so no later read hits an unwritten entry
      for (int k = 0; k < KEYS; k++)
         for (int e = 0; e < ALPHA; e++) begin
            if (k == KEYS - 1) val = FLOOD_LETTER;
            else if ($urandom_range(0, 7) == 0) val = 5'($urandom_range(ALPHA, 31));
            else val = 5'($urandom_range(0, ALPHA - 1));
            send_request(polysub_pkg::KIND_LOAD, 3'(k), 5'(e), val, 1'b0, 1'b0, 5'd0);
         end

      for (int ph = 0; ph < PHASES; ph++) begin
         // registers change only with the block idle
         settle();
         write_csr(polysub_pkg::CSR_NUM_KEYS, phase_keys[ph]);
         write_csr(polysub_pkg::CSR_DECODE_MODE,
                   {{(polysub_pkg::CSR_DATA_W - 1){1'b0}}, phase_dec[ph]});
         sender_gaps = ($urandom_range(0, 2) != 0);
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               send_request(polysub_pkg::KIND_LETTER, 3'($urandom), 5'($urandom),
                            pick_letter(), 1'b0, 1'b0, 5'd0);
               counted++;
            end else if (r < 85) begin
               // some loads aim past the alphabet and must be dropped
               eidx = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(ALPHA, 31))
                                                  : 5'($urandom_range(0, ALPHA - 1));
               val  = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(ALPHA, 31))
                                                  : 5'($urandom_range(0, ALPHA - 1));
               send_request(polysub_pkg::KIND_LOAD, 3'($urandom), eidx, val,
                            1'b0, 1'b0, 5'd0);
               if (eidx < ALPHA) counted++;
            end else if (r < 93) begin
               send_request(polysub_pkg::KIND_RESTART, 3'($urandom), 5'($urandom),
                            5'($urandom), 1'b0, 1'b0, 5'd0);
               counted++;
            end else if (r < 96) begin
               send_request(KIND_IGNORED, 3'($urandom), 5'($urandom), 5'($urandom),
                            1'b0, 1'b0, 5'd0);
            end else begin
               // hold off until every owed response is in
               settle();
            end
         end
         // leave the position on the last alphabet, so a smaller count next
         // phase finds it out of range
         while (text_pos != keys_in_use() - 1)
            send_request(polysub_pkg::KIND_LETTER, 3'($urandom), 5'($urandom),
                         pick_letter(), 1'b0, 1'b0, 5'd0);
      end

      settle();
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
